[rtl/segint_pkg.sv]
// segint_pkg: widths, payload types and orientation codes for the segment intersection test
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package segint_pkg;

  // coordinate width and derived arithmetic widths
  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 1;

  // orientation of an ordered triple
  typedef logic [1:0] orient_t;
  localparam orient_t ORIENT_COLLINEAR = 2'd0;
  localparam orient_t ORIENT_CW        = 2'd1;
  localparam orient_t ORIENT_CCW       = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // input transaction payload
  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  // output transaction payload
  typedef struct packed {
    logic intersects;
  } seg_result_t;

  // load enables of the product and sign stages
  typedef struct packed {
    logic ld2;
    logic ld3;
  } stage_en_t;

endpackage

`default_nettype wire

[rtl/segint_if.sv]
// segint_in_if / segint_out_if: valid-ready channels for segment pairs and results
// depends on segint_pkg for the payload types
`default_nettype none

interface segint_in_if;
  import segint_pkg::*;
  logic      valid;
  logic      ready;
  seg_pair_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface segint_out_if;
  import segint_pkg::*;
  logic        valid;
  logic        ready;
  seg_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/segment_intersection_test_core.sv]
// segment_intersection_test_core: closed 2D segment intersection by orientation tests
// one transaction per cycle sustained while seg_out.ready is high
// stages: differences and box compares, products, cross sign, combine into the output register
// a stalled output holds every full stage that has only full stages after it; nothing is dropped or repeated
// reset (rst, synchronous) clears the stage valid bits only
// depends on segint_pkg, segint_if and segint_cross
`default_nettype none

module segment_intersection_test_core (
  input  wire         clk,
  input  wire         rst,
  segint_in_if.sink   seg_in,
  segint_out_if.source seg_out
);
  import segint_pkg::*;

  logic v1, v2, v3, v4;
  logic ld1, ld2, ld3, ld4;
  stage_en_t en;

  point_t p1, q1, p2, q2;

  // stage 1 registers: shared and per-test differences, collinear qualifiers
  diff_t d1x, d1y, d2x, d2y;
  diff_t ex [4];
  diff_t ey [4];
  logic [3:0] coll1, coll2, coll3;
  logic [3:0] coll_next;

  orient_t o [4];
  logic    hit;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  // m inside the closed box of a-b and on neither endpoint
  function automatic logic coll_ok(point_t a, point_t m, point_t b);
    logic bx, by;
    bx = (m.x <= a.x || m.x <= b.x) && (m.x >= a.x || m.x >= b.x);
    by = (m.y <= a.y || m.y <= b.y) && (m.y >= a.y || m.y >= b.y);
    return bx && by && (m != a) && (m != b);
  endfunction

  // pipeline control: a stage loads when empty or when the next one loads
  assign ld4 = !v4 || seg_out.ready;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign en.ld2 = ld2;
  assign en.ld3 = ld3;
  assign seg_in.ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= seg_in.valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  // unpack the endpoints
  always_comb begin
    p1.x = seg_in.data.first_start_x;
    p1.y = seg_in.data.first_start_y;
    q1.x = seg_in.data.first_end_x;
    q1.y = seg_in.data.first_end_y;
    p2.x = seg_in.data.second_start_x;
    p2.y = seg_in.data.second_start_y;
    q2.x = seg_in.data.second_end_x;
    q2.y = seg_in.data.second_end_y;
    coll_next[0] = coll_ok(p1, p2, q1);
    coll_next[1] = coll_ok(p1, q2, q1);
    coll_next[2] = coll_ok(p2, p1, q2);
    coll_next[3] = coll_ok(p2, q1, q2);
  end

  // stage 1: coordinate differences and the collinear qualifiers
  always_ff @(posedge clk) begin
    if (ld1) begin
      d1x   <= sub_c(q1.x, p1.x);
      d1y   <= sub_c(q1.y, p1.y);
      d2x   <= sub_c(q2.x, p2.x);
      d2y   <= sub_c(q2.y, p2.y);
      ex[0] <= sub_c(p2.x, q1.x);
      ey[0] <= sub_c(p2.y, q1.y);
      ex[1] <= sub_c(q2.x, q1.x);
      ey[1] <= sub_c(q2.y, q1.y);
      ex[2] <= sub_c(p1.x, q2.x);
      ey[2] <= sub_c(p1.y, q2.y);
      ex[3] <= sub_c(q1.x, q2.x);
      ey[3] <= sub_c(q1.y, q2.y);
      coll1 <= coll_next;
    end
  end

  // collinear qualifiers ride alongside the products and the signs
  always_ff @(posedge clk) begin
    if (ld2) coll2 <= coll1;
    if (ld3) coll3 <= coll2;
  end

  // four orientation tests: two against the first segment, two against the second
  segint_cross u_cross0 (
    .clk(clk), .en(en), .by_ay(d1y), .cx_bx(ex[0]), .bx_ax(d1x), .cy_by(ey[0]), .orient(o[0])
  );
  segint_cross u_cross1 (
    .clk(clk), .en(en), .by_ay(d1y), .cx_bx(ex[1]), .bx_ax(d1x), .cy_by(ey[1]), .orient(o[1])
  );
  segint_cross u_cross2 (
    .clk(clk), .en(en), .by_ay(d2y), .cx_bx(ex[2]), .bx_ax(d2x), .cy_by(ey[2]), .orient(o[2])
  );
  segint_cross u_cross3 (
    .clk(clk), .en(en), .by_ay(d2y), .cx_bx(ex[3]), .bx_ax(d2x), .cy_by(ey[3]), .orient(o[3])
  );

  // stage 4: general crossing or a qualified collinear point
  always_comb begin
    hit = (o[0] != o[1] && o[2] != o[3]) ||
          (o[0] == ORIENT_COLLINEAR && coll3[0]) ||
          (o[1] == ORIENT_COLLINEAR && coll3[1]) ||
          (o[2] == ORIENT_COLLINEAR && coll3[2]) ||
          (o[3] == ORIENT_COLLINEAR && coll3[3]);
  end

  always_ff @(posedge clk) begin
    if (ld4) seg_out.data.intersects <= hit;
  end

  assign seg_out.valid = v4;

  // an empty output stage never holds back the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v4 |-> seg_in.ready)
    else $error("input stalled with an empty output stage");

  // an accepted transaction occupies the first stage next cycle
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (seg_in.valid && seg_in.ready) |=> v1)
    else $error("accepted transaction lost at the first stage");

  // a held stage keeps its transaction
  a_stall_keeps_s3: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ld4) |=> v3)
    else $error("stalled transaction dropped from the sign stage");

endmodule

`default_nettype wire

[rtl/segint_cross.sv]
// segint_cross: two-stage cross product and sign for one orientation test
// depends on segint_pkg; stage enables come from the top level pipeline control
`default_nettype none

module segint_cross (
  input  wire                    clk,
  input  segint_pkg::stage_en_t  en,
  input  segint_pkg::diff_t      by_ay,
  input  segint_pkg::diff_t      cx_bx,
  input  segint_pkg::diff_t      bx_ax,
  input  segint_pkg::diff_t      cy_by,
  output segint_pkg::orient_t    orient
);
  import segint_pkg::*;

  logic signed [PROD_W-1:0]  prod_a;
  logic signed [PROD_W-1:0]  prod_b;
  logic signed [CROSS_W-1:0] cross_next;
  orient_t                   orient_next;

  // stage 2: the two partial products
  always_ff @(posedge clk) begin
    if (en.ld2) begin
      prod_a <= by_ay * cx_bx;
      prod_b <= bx_ax * cy_by;
    end
  end

  // stage 3: difference and its sign
  always_comb begin
    cross_next = CROSS_W'(prod_a) - CROSS_W'(prod_b);
    if (cross_next == '0) begin
      orient_next = ORIENT_COLLINEAR;
    end else if (cross_next[CROSS_W-1]) begin
      orient_next = ORIENT_CCW;
    end else begin
      orient_next = ORIENT_CW;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      orient <= orient_next;
    end
  end

endmodule

`default_nettype wire

[sim/testbench.sv]
// testbench: self-checking bench for segment_intersection_test_core, directed table then random
// pairs checked against an in-bench orientation predictor; depends on segint_pkg and segint_if
`timescale 1ns / 100ps

module testbench;
  import segint_pkg::*;

  localparam int RANDOM_PAIRS = 550;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // one row of the directed table; known rows carry a typed-in answer
  typedef struct {
    seg_pair_t pair;
    bit        known;
    logic      hit;
  } seg_row_t;

  logic clk;
  logic rst;

  segint_in_if  seg_in_ch ();
  segint_out_if seg_out_ch ();

  segment_intersection_test_core dut (
    .clk     (clk),
    .rst     (rst),
    .seg_in  (seg_in_ch),
    .seg_out (seg_out_ch)
  );

  logic     expected_hits[$];
  seg_row_t directed_rows[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // orientation of the ordered triple a, b, c from the exact cross product
  function automatic orient_t orientation_of(input longint ax, input longint ay,
                                             input longint bx, input longint by,
                                             input longint cx, input longint cy);
    longint cross_val;
    cross_val = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
    if (cross_val == 0) return ORIENT_COLLINEAR;
    return (cross_val > 0) ? ORIENT_CW : ORIENT_CCW;
  endfunction

  // collinear point m counts if inside the box of a-b and not on either endpoint
  function automatic bit collinear_on(input orient_t o,
                                      input longint ax, input longint ay,
                                      input longint mx, input longint my,
                                      input longint bx, input longint by);
    bit in_box;
    in_box = (mx <= ((ax > bx) ? ax : bx)) && (mx >= ((ax < bx) ? ax : bx)) &&
             (my <= ((ay > by) ? ay : by)) && (my >= ((ay < by) ? ay : by));
    return (o == ORIENT_COLLINEAR) && in_box && !(ax == mx && ay == my) &&
           !(bx == mx && by == my);
  endfunction

  // predicted intersects flag for one segment pair
  function automatic logic segments_cross(input seg_pair_t p);
    longint  p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y;
    orient_t o1, o2, o3, o4;
    p1x = p.first_start_x;  p1y = p.first_start_y;
    q1x = p.first_end_x;    q1y = p.first_end_y;
    p2x = p.second_start_x; p2y = p.second_start_y;
    q2x = p.second_end_x;   q2y = p.second_end_y;
    o1 = orientation_of(p1x, p1y, q1x, q1y, p2x, p2y);
    o2 = orientation_of(p1x, p1y, q1x, q1y, q2x, q2y);
    o3 = orientation_of(p2x, p2y, q2x, q2y, p1x, p1y);
    o4 = orientation_of(p2x, p2y, q2x, q2y, q1x, q1y);
    return ((o1 != o2) && (o3 != o4)) ||
           collinear_on(o1, p1x, p1y, p2x, p2y, q1x, q1y) ||
           collinear_on(o2, p1x, p1y, q2x, q2y, q1x, q1y) ||
           collinear_on(o3, p2x, p2y, p1x, p1y, q2x, q2y) ||
           collinear_on(o4, p2x, p2y, q1x, q1y, q2x, q2y);
  endfunction

  function automatic seg_pair_t mk_pair(input int a, input int b, input int c, input int d,
                                        input int e, input int f, input int g, input int h);
    seg_pair_t p;
    p.first_start_x  = coord_t'(a);
    p.first_start_y  = coord_t'(b);
    p.first_end_x    = coord_t'(c);
    p.first_end_y    = coord_t'(d);
    p.second_start_x = coord_t'(e);
    p.second_start_y = coord_t'(f);
    p.second_end_x   = coord_t'(g);
    p.second_end_y   = coord_t'(h);
    return p;
  endfunction

  function automatic void add_row(input seg_pair_t p, input bit known, input logic hit);
    seg_row_t r;
    r.pair  = p;
    r.known = known;
    r.hit   = hit;
    directed_rows.push_back(r);
  endfunction

  // random pair, biased towards collinear, touching and extreme geometry
  function automatic seg_pair_t random_pair();
    int mode;
    int c[8];
    int ext[7];
    int bx, by, dx, dy, src, dst;
    ext  = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    mode = $urandom_range(99);
    if (mode < 25) begin
      // full range, every bit toggles
      foreach (c[i]) c[i] = int'($urandom_range(65535)) - 32768;
    end else if (mode < 50) begin
      // small grid, plenty of touching and collinear cases
      foreach (c[i]) c[i] = int'($urandom_range(32)) - 16;
    end else if (mode < 75) begin
      // four points on one line
      bx = int'($urandom_range(4000)) - 2000;
      by = int'($urandom_range(4000)) - 2000;
      dx = int'($urandom_range(60)) - 30;
      dy = int'($urandom_range(60)) - 30;
      for (int k = 0; k < 4; k++) begin
        src = int'($urandom_range(20)) - 10;
        c[2*k]   = bx + src * dx;
        c[2*k+1] = by + src * dy;
      end
    end else if (mode < 90) begin
      // second segment reuses an endpoint of the first
      foreach (c[i]) c[i] = int'($urandom_range(400)) - 200;
      src = 2 * int'($urandom_range(1));
      dst = 4 + 2 * int'($urandom_range(1));
      c[dst]   = c[src];
      c[dst+1] = c[src+1];
    end else begin
      foreach (c[i]) c[i] = ext[$urandom_range(6)];
    end
    return mk_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  // drive one pair, wait for the handshake, then queue its expected flag
  task automatic send_pair(input seg_pair_t p, input logic hit);
    while ($urandom_range(99) < src_idle_pct) begin
      seg_in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    seg_in_ch.valid <= 1'b1;
    seg_in_ch.data  <= p;
    do @(posedge clk); while (!seg_in_ch.ready);
    expected_hits.push_back(hit);
  endtask

  // receiver: random back-pressure and result checking
  always @(posedge clk) begin
    logic want;
    if (rst) begin
      seg_out_ch.ready <= 1'b0;
    end else begin
      seg_out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      if (seg_out_ch.valid && seg_out_ch.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none actual %0b",
                   $time, seg_out_ch.data.intersects);
          mismatch_count++;
        end else begin
          want = expected_hits.pop_front();
          if (seg_out_ch.data.intersects !== want) begin
            $display("%0t: intersects mismatch, expected %0b actual %0b",
                     $time, want, seg_out_ch.data.intersects);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    int total;
    int k;
    seg_pair_t p;
    rst              = 1'b1;
    seg_in_ch.valid  = 1'b0;
    seg_in_ch.data   = '0;

    // known answers: degenerate, extremes and the endpoint rules
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0);
    add_row(mk_pair(0, 0, 10, 10, 0, 10, 10, 0), 1'b1, 1'b1);
    add_row(mk_pair(0, 0, 10, 0, 0, 5, 10, 5), 1'b1, 1'b0);
    add_row(mk_pair(0, 0, 10, 0, 5, 0, 15, 0), 1'b1, 1'b1);
    // collinear, touching only at an endpoint: excluded
    add_row(mk_pair(0, 0, 10, 0, 10, 0, 20, 0), 1'b1, 1'b0);
    // shared endpoint at a corner passes the orientation test
    add_row(mk_pair(0, 0, 10, 0, 10, 0, 10, 10), 1'b1, 1'b1);
    add_row(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1'b1, 1'b1);
    // point segment inside the other segment, and on its endpoint
    add_row(mk_pair(5, 5, 5, 5, 0, 0, 10, 10), 1'b1, 1'b1);
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 10, 10), 1'b1, 1'b0);
    // identical segments: every collinear point is an endpoint
    add_row(mk_pair(0, 0, 10, 10, 0, 0, 10, 10), 1'b1, 1'b0);
    add_row(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1, 1'b0);
    add_row(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
            1'b1, 1'b0);
    // predictor-checked rows
    add_row(mk_pair(32767, -32768, -32768, 32767, 0, 0, 100, -5), 1'b0, 1'b0);
    add_row(mk_pair(0, 0, 10, 0, 5, 0, 5, 10), 1'b0, 1'b0);
    add_row(mk_pair(0, 0, 20, 0, 5, 0, 10, 0), 1'b0, 1'b0);
    add_row(mk_pair(0, 0, 5, 5, 10, 10, 20, 20), 1'b0, 1'b0);
    add_row(mk_pair(-32768, 32767, -32768, 32767, 32767, -32768, -32768, 32767), 1'b0, 1'b0);
    add_row(mk_pair(0, 0, 10, 10, 11, 0, 0, 11), 1'b0, 1'b0);
    add_row(mk_pair(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767), 1'b0, 1'b0);
    add_row(mk_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1'b0, 1'b0);
    add_row(mk_pair(-32768, -32768, 32767, 32767, -32767, -32767, 32766, 32766), 1'b0, 1'b0);
    add_row(mk_pair(1, -1, -1, 1, 0, 0, 32767, -32768), 1'b0, 1'b0);

    total = directed_rows.size() + RANDOM_PAIRS;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table, then random pairs; idling pattern changes by thirds
    for (k = 0; k < total; k++) begin
      if (k < total / 3) begin
        src_idle_pct = 25;
        snk_idle_pct = 76;
      end else if (k < 2 * total / 3) begin
        src_idle_pct = 76;
        snk_idle_pct = 25;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (k < directed_rows.size()) begin
        p = directed_rows[k].pair;
        send_pair(p, directed_rows[k].known ? directed_rows[k].hit : segments_cross(p));
      end else begin
        p = random_pair();
        send_pair(p, segments_cross(p));
      end
    end
    seg_in_ch.valid <= 1'b0;

    // drain outstanding results
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
